@@ hdl/rtc_pkg.sv @@
`timescale 1ns / 1ps

package rtc_pkg;

  localparam int BYTE_W     = 8;
  localparam int KEY_W      = 64;
  localparam int CFG_ADDR_W = 2;

  // register indexes on the configuration port
  localparam logic [CFG_ADDR_W-1:0] REG_KEY_LETTERS = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_KEY_LENGTH  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_CIPHER_MODE = 2'd2;

  localparam logic MODE_ENCRYPT = 1'b0;
  localparam logic MODE_DECRYPT = 1'b1;

  localparam logic [BYTE_W-1:0] SPACE_CODE = 8'd32;
  // pad letters run upwards and stop just below this code ('z' + 1)
  localparam logic [BYTE_W-1:0] PAD_END    = 8'd123;

endpackage

@@ hdl/row_transposition_cipher.sv @@
`timescale 1ns / 1ps

// Row transposition cipher, one message byte per request.
//
// s_axis: tdata = data_byte, tlast = last_byte. Spaces are dropped; other
//   bytes fill a row of key_length bytes. A request that completes a row,
//   or carries tlast with bytes pending, starts that row's emission.
// m_axis: one permuted byte per row column; tlast = row_last, tuser carries
//   message_last and length_error. A short final row is padded with
//   ascending letters ending at 'z'; in decrypt mode it flags length_error.
// cfg: write enable, register index and data; key_letters, key_length,
//   cipher_mode. Each write to one of these registers reruns the key ranking.
// Timing: a request that does not close a row only stores its byte. A
//   closing request starts emission; each byte goes through S_ROW (column
//   map read, row read issued) and S_OUT (row data in, output register
//   loaded). s_axis_tready is low during emission.
// Reset and each defined-register write run a ranking pass, one key position
//   per cycle (key_length, clamped to 1..MAX_KEY) with s_axis_tready low.
// A stalled receiver holds the output register and freezes emission; the
//   last byte of a row waits in the output register while input resumes.
module row_transposition_cipher import rtc_pkg::*; #(
  parameter int MAX_KEY = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  // config port
  input  logic                  cfg_en,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [KEY_W-1:0]      cfg_data,
  // input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // [7:0] data_byte
  input  logic                  s_axis_tlast,   // last_byte
  // output stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [7:0]            m_axis_tdata,   // [7:0] out_byte
  output logic                  m_axis_tlast,   // row_last
  output logic [1:0]            m_axis_tuser    // [0] message_last, [1] length_error
);

  localparam int IDX_W = $clog2(MAX_KEY);
  localparam int CNT_W = $clog2(MAX_KEY + 1);

  localparam logic [1:0] S_IDLE = 2'd0;  // taking requests
  localparam logic [1:0] S_ROW  = 2'd1;  // column map data in, row read issued
  localparam logic [1:0] S_OUT  = 2'd2;  // row data in, waiting for output slot

  // configuration registers
  logic [KEY_W-1:0]  key_letters;
  logic [3:0]        key_length;
  logic              cipher_mode;
  logic              cfg_hit;

  logic [1:0]        state;
  logic [CNT_W-1:0]  fill;
  logic [CNT_W-1:0]  row_fill;   // bytes held by the row being emitted
  logic [IDX_W-1:0]  col;        // output column
  logic              msg_last;
  logic              padded;
  logic [IDX_W-1:0]  src;
  logic              pad_sel;

  logic [CNT_W-1:0]  row_len;
  logic              accept;
  logic              keep;
  logic [CNT_W-1:0]  fill_next;
  logic              emit;
  logic              out_load;
  logic              col_end;
  logic [BYTE_W-1:0] pad_byte;

  logic              rank_busy;
  logic [IDX_W-1:0]  map_addr;
  logic [IDX_W-1:0]  map_data;
  logic [BYTE_W-1:0] row_data;

  // ---------------- configuration ----------------
  always_comb begin
    cfg_hit = 1'b0;
    if (cfg_en) begin
      unique case (cfg_addr) inside
        REG_KEY_LETTERS, REG_KEY_LENGTH, REG_CIPHER_MODE: cfg_hit = 1'b1;
        default: cfg_hit = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_letters <= '0;
      key_length  <= 4'd1;
      cipher_mode <= MODE_ENCRYPT;
    end else if (cfg_en) begin
      unique case (cfg_addr)
        REG_KEY_LETTERS: key_letters <= cfg_data;
        REG_KEY_LENGTH:  key_length  <= cfg_data[3:0];
        REG_CIPHER_MODE: cipher_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // row width, zero read as one and clamped to the buffer depth
  always_comb begin
    if (key_length == 4'd0) begin
      row_len = CNT_W'(1);
    end else if (int'(key_length) > MAX_KEY) begin
      row_len = CNT_W'(MAX_KEY);
    end else begin
      row_len = CNT_W'(key_length);
    end
  end

  // ---------------- request side ----------------
  assign s_axis_tready = (state == S_IDLE) && !rank_busy;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign keep          = (s_axis_tdata != SPACE_CODE) && (int'(fill) < MAX_KEY);
  assign fill_next     = keep ? fill + CNT_W'(1) : fill;
  // full row, or a flush with something pending
  assign emit          = (fill_next >= row_len) || (s_axis_tlast && fill_next != '0);

  // ---------------- emission ----------------
  assign out_load = (state == S_OUT) && (!m_axis_tvalid || m_axis_tready);
  assign col_end  = (CNT_W'(col) == row_len - CNT_W'(1));
  // column map address: next column while a byte waits, column 0 when idle
  assign map_addr = (state == S_OUT) ? col + IDX_W'(1) : '0;
  // pad letter for a row position past the stored bytes: 123 - n + pos
  assign pad_byte = PAD_END - BYTE_W'(row_len) + BYTE_W'(src);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            fill <= fill_next;
            if (emit) begin
              row_fill <= fill_next;
              msg_last <= s_axis_tlast;
              padded   <= fill_next < row_len;
              col      <= '0;
              state    <= S_ROW;
            end
          end
        end
        S_ROW: begin
          src     <= map_data;
          pad_sel <= CNT_W'(map_data) >= row_fill;
          state   <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            if (col_end) begin
              fill  <= '0;
              state <= S_IDLE;
            end else begin
              col   <= col + IDX_W'(1);
              state <= S_ROW;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata    <= pad_sel ? pad_byte : row_data;
      m_axis_tlast    <= col_end;
      m_axis_tuser[0] <= msg_last && col_end;
      m_axis_tuser[1] <= padded && (cipher_mode == MODE_DECRYPT);
    end
  end

  // ---------------- stores ----------------
  rtc_rank_unit #(
    .MAX_KEY     (MAX_KEY)
  ) u_rank (
    .clk         (clk),
    .rst         (rst),
    .start       (cfg_hit),
    .key_letters (key_letters),
    .row_len     (row_len),
    .cipher_mode (cipher_mode),
    .busy        (rank_busy),
    .rd_addr     (map_addr),
    .rd_data     (map_data)
  );

  rtc_row_buffer #(
    .MAX_KEY (MAX_KEY)
  ) u_row (
    .clk     (clk),
    .wr_en   (accept && keep),
    .wr_addr (fill[IDX_W-1:0]),
    .wr_data (s_axis_tdata),
    .rd_en   (state == S_ROW),
    .rd_addr (map_data),
    .rd_data (row_data)
  );

endmodule

@@ hdl/rtc_row_buffer.sv @@
`timescale 1ns / 1ps

// One row of message bytes; registered read.
module rtc_row_buffer import rtc_pkg::*; #(
  parameter int MAX_KEY = 8,
  localparam int IDX_W = $clog2(MAX_KEY)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_addr,
  input  logic [BYTE_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [IDX_W-1:0]  rd_addr,
  output logic [BYTE_W-1:0] rd_data
);

  logic [BYTE_W-1:0] mem [MAX_KEY];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hdl/rtc_rank_unit.sv @@
`timescale 1ns / 1ps

// Walks the key one position a cycle, ranks that letter against the
// others and writes the column map: encrypt map[k] = rank(k),
// decrypt map[rank(k)] = k. Registered read port for the emitter.
module rtc_rank_unit import rtc_pkg::*; #(
  parameter int MAX_KEY = 8,
  localparam int IDX_W = $clog2(MAX_KEY),
  localparam int CNT_W = $clog2(MAX_KEY + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [KEY_W-1:0] key_letters,
  input  logic [CNT_W-1:0] row_len,
  input  logic             cipher_mode,
  output logic             busy,
  input  logic [IDX_W-1:0] rd_addr,
  output logic [IDX_W-1:0] rd_data
);

  logic [IDX_W-1:0]  pos;
  logic [BYTE_W-1:0] chars [MAX_KEY];
  logic [CNT_W-1:0]  rank;
  logic [IDX_W-1:0]  wr_addr;
  logic [IDX_W-1:0]  wr_data;
  logic [IDX_W-1:0]  map [MAX_KEY];

  always_comb begin
    for (int j = 0; j < MAX_KEY; j++) begin
      chars[j] = key_letters[j*BYTE_W +: BYTE_W];
    end
  end

  // ties go to the lower position
  always_comb begin
    rank = '0;
    for (int j = 0; j < MAX_KEY; j++) begin
      if (CNT_W'(j) < row_len &&
          (chars[j] < chars[pos] || (chars[j] == chars[pos] && IDX_W'(j) < pos))) begin
        rank = rank + CNT_W'(1);
      end
    end
  end

  assign wr_addr = (cipher_mode == MODE_DECRYPT) ? rank[IDX_W-1:0] : pos;
  assign wr_data = (cipher_mode == MODE_DECRYPT) ? pos : rank[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      pos  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      pos  <= '0;
    end else if (busy) begin
      pos <= pos + IDX_W'(1);
      if (CNT_W'(pos) == row_len - CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      map[wr_addr] <= wr_data;
    end
    rd_data <= map[rd_addr];
  end

endmodule
